### rtl/core/ehp_pkg.sv
// Shared types and constants for the Ethernet/VLAN header parser.
// No dependencies.
`timescale 1ns / 1ps

package ehp_pkg;

    localparam int MAX_HEADER_DEF = 64;

    localparam int OFFSET_W = 8;   // byte position, saturates at 255
    localparam int HLEN_W   = 7;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
    localparam logic [OFFSET_W-1:0] MAC_LAST   = 8'd11;
    localparam logic [OFFSET_W-1:0] TAG_LEN    = 8'd4;
    localparam logic [OFFSET_W-1:0] PBB_NEED   = 8'd32;
    localparam logic [HLEN_W-1:0]   PBB_HLEN   = 7'd18;
    localparam logic [3:0]          TAG_SAT    = 4'd15;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_VLAN_TPID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PBB_TYPE  = 1'b1;

    localparam logic [15:0] VLAN_TPID_RST = 16'h8100;
    localparam logic [15:0] PBB_TYPE_RST  = 16'h88E7;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_OVERLONG = 2'd2
    } status_t;

    typedef struct packed {
        status_t            status;
        logic               multicast;
        logic [15:0]        ethertype;
        logic [HLEN_W-1:0]  header_length;
        logic [3:0]         tag_count;
        logic [11:0]        first_vlan_id;
        logic               vlan_seen;
        logic               pbb_frame;
    } result_t;

endpackage

### rtl/core/ehp_parser.sv
// Per-frame parse state and the byte step logic of the header parser.
// Depends on ehp_pkg.
`timescale 1ns / 1ps

module ehp_parser
    import ehp_pkg::*;
#(
    parameter int MAX_HEADER = MAX_HEADER_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [15:0] vlan_tpid,
    input  logic [15:0] pbb_ethertype,
    output logic        emit,
    output result_t     res
);

    typedef enum logic [2:0] {
        PH_MAC,
        PH_TYPE_HI,
        PH_TYPE_LO,
        PH_TCI_HI,
        PH_TCI_LO,
        PH_PROTO_HI,
        PH_PROTO_LO,
        PH_PBB
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [OFFSET_W-1:0]   offset_reg, offset_next;
    logic [15:0]           type_reg, type_next;
    logic                  mc_reg, mc_next;
    logic [11:0]           vid_reg, vid_next;
    logic [3:0]            tags_reg, tags_next;
    logic                  done_reg, done_next;
    logic                  pbb_reg, pbb_next;

    logic [15:0]           word;
    logic                  tt_go;
    logic                  tt_outer;
    logic                  too_long;

    assign word = type_reg | {8'h00, data_byte};

    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        type_next   = type_reg;
        mc_next     = mc_reg;
        vid_next    = vid_reg;
        tags_next   = tags_reg;
        done_next   = done_reg;
        pbb_next    = pbb_reg;
        tt_go       = 1'b0;
        tt_outer    = 1'b0;
        too_long    = 1'b0;
        emit        = 1'b0;
        res         = '0;

        if (!done_reg)
        begin
            if (offset_reg != OFFSET_MAX)
                offset_next = offset_reg + 1'b1;

            unique case (phase_reg)
                PH_MAC:
                begin
                    if (offset_reg == '0)
                        mc_next = data_byte[0];
                    if (offset_reg >= MAC_LAST)
                        phase_next = PH_TYPE_HI;
                end
                PH_TYPE_HI:
                begin
                    type_next  = {data_byte, 8'h00};
                    phase_next = PH_TYPE_LO;
                end
                PH_TCI_HI:
                begin
                    type_next  = {data_byte, 8'h00};
                    phase_next = PH_TCI_LO;
                end
                PH_PROTO_HI:
                begin
                    type_next  = {data_byte, 8'h00};
                    phase_next = PH_PROTO_LO;
                end
                PH_TYPE_LO:
                begin
                    tt_go    = 1'b1;
                    tt_outer = 1'b1;
                end
                PH_TCI_LO:
                begin
                    // only the outermost tag's id is kept
                    if (tags_reg == '0)
                        vid_next = word[11:0];
                    phase_next = PH_PROTO_HI;
                end
                PH_PROTO_LO:
                begin
                    if (tags_reg != TAG_SAT)
                        tags_next = tags_reg + 1'b1;
                    tt_go = 1'b1;
                end
                PH_PBB:
                begin
                    if (offset_next >= PBB_NEED)
                    begin
                        emit              = 1'b1;
                        res.status        = ST_OK;
                        res.ethertype     = type_reg;
                        res.header_length = PBB_HLEN;
                    end
                end
            endcase

            if (tt_go)
            begin
                // PBB check wins when both types match
                if (tt_outer && word == pbb_ethertype)
                begin
                    pbb_next   = 1'b1;
                    type_next  = word;
                    phase_next = PH_PBB;
                end
                else if (word == vlan_tpid)
                begin
                    too_long = ({1'b0, offset_next} + {1'b0, TAG_LEN})
                             > (OFFSET_W + 1)'(MAX_HEADER);
                    if (too_long)
                    begin
                        emit              = 1'b1;
                        res.status        = ST_OVERLONG;
                        res.ethertype     = word;
                        res.header_length = offset_next[HLEN_W-1:0];
                    end
                    else
                        phase_next = PH_TCI_HI;
                end
                else
                begin
                    emit              = 1'b1;
                    res.status        = ST_OK;
                    res.ethertype     = word;
                    res.header_length = offset_next[HLEN_W-1:0];
                end
            end

            if (!emit && last_byte)
            begin
                emit              = 1'b1;
                res.status        = ST_SHORT;
                res.ethertype     = '0;
                res.header_length = offset_next[HLEN_W-1:0];
            end

            done_next = emit;
        end

        res.multicast     = mc_next;
        res.tag_count     = tags_next;
        res.first_vlan_id = vid_next;
        res.vlan_seen     = (tags_next != '0);
        res.pbb_frame     = pbb_next;

        // end of frame: ready for the next one
        if (last_byte)
        begin
            phase_next  = PH_MAC;
            offset_next = '0;
            type_next   = '0;
            mc_next     = 1'b0;
            vid_next    = '0;
            tags_next   = '0;
            done_next   = 1'b0;
            pbb_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAC;
            offset_reg <= '0;
            type_reg   <= '0;
            mc_reg     <= 1'b0;
            vid_reg    <= '0;
            tags_reg   <= '0;
            done_reg   <= 1'b0;
            pbb_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            type_reg   <= type_next;
            mc_reg     <= mc_next;
            vid_reg    <= vid_next;
            tags_reg   <= tags_next;
            done_reg   <= done_next;
            pbb_reg    <= pbb_next;
        end
    end

endmodule

### rtl/core/ethernet_header_parser_top.sv
// Ethernet/VLAN header parser, top level.
// The result is registered: valid in the cycle after its completing byte is accepted.
// Throughput: one byte per cycle; the single output register takes a result while
// the previous one drains, so the input stalls only while out_ready is low.
// Reset: frame state cleared, tag type 0x8100, PBB type 0x88E7, no result pending.
// Depends on ehp_pkg and ehp_parser.
`timescale 1ns / 1ps

module ethernet_header_parser_top
    import ehp_pkg::*;
#(
    parameter int MAX_HEADER = MAX_HEADER_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]           cfg_data,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic                  multicast,
    output logic [15:0]           ethertype,
    output logic [HLEN_W-1:0]     header_length,
    output logic [3:0]            tag_count,
    output logic [11:0]           first_vlan_id,
    output logic                  vlan_seen,
    output logic                  pbb_frame
);

    logic [15:0] tpid_reg;
    logic [15:0] pbb_type_reg;
    logic        out_valid_reg;
    result_t     res_reg;

    logic        step;
    logic        emit;
    result_t     res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpid_reg     <= VLAN_TPID_RST;
            pbb_type_reg <= PBB_TYPE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_VLAN_TPID: tpid_reg     <= cfg_data;
                CFG_PBB_TYPE:  pbb_type_reg <= cfg_data;
            endcase
        end
    end

    ehp_parser #(
        .MAX_HEADER (MAX_HEADER)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .vlan_tpid     (tpid_reg),
        .pbb_ethertype (pbb_type_reg),
        .emit          (emit),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
            res_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign multicast     = res_reg.multicast;
    assign ethertype     = res_reg.ethertype;
    assign header_length = res_reg.header_length;
    assign tag_count     = res_reg.tag_count;
    assign first_vlan_id = res_reg.first_vlan_id;
    assign vlan_seen     = res_reg.vlan_seen;
    assign pbb_frame     = res_reg.pbb_frame;

endmodule

### rtl/core/ehp_checker.sv
// Port-level checks for the header parser, bound to the top level.
// Depends on ehp_pkg and ethernet_header_parser_top.
`timescale 1ns / 1ps

module ehp_checker
    import ehp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [1:0]        status,
    input  logic [15:0]       ethertype,
    input  logic [HLEN_W-1:0] header_length,
    input  logic [3:0]        tag_count,
    input  logic              vlan_seen,
    input  logic              pbb_frame
);

    // a held result blocks new bytes
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while result stalled");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(ethertype) && $stable(header_length) && $stable(tag_count))
        else $error("stalled item changed");

    a_vlan_seen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> vlan_seen == (tag_count != 4'd0))
        else $error("vlan_seen disagrees with tag_count");

    // ordinary end: offset is the Ethernet header plus the skipped tags
    a_hlen_tags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK && !pbb_frame && tag_count != TAG_SAT
            |-> header_length == HLEN_W'(7'd14 + {1'b0, tag_count, 2'b00}))
        else $error("header_length does not match tag count");

    a_pbb_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK && pbb_frame
            |-> header_length == PBB_HLEN && tag_count == 4'd0)
        else $error("bad backbone-bridged result");

endmodule

bind ethernet_header_parser_top ehp_checker u_ehp_checker (.*);
